// ===== design/mfo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfo_pkg
// Shared types, widths and constants of the motor feedback odometry block.
// ----------------------------------------------------------------------------
package mfo_pkg;

    // stream word widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 144;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    // working width of the position math
    localparam int P_W = 24;

    // shared divider: dividend width, step counter width and step counts
    localparam int DIV_DW     = 53;
    localparam int DIV_CW     = 6;
    localparam int WRAP_BITS  = 23;
    localparam int DIST_BITS  = 44;
    localparam int ANG_BITS   = 53;

    // shared multiplier operand widths
    localparam int MUL_AW = 23;
    localparam int MUL_BW = 31;
    localparam int MUL_W  = MUL_AW + MUL_BW;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POS_MAX      = 3'd0,
        CFG_POS_MIN      = 3'd1,
        CFG_POS_SPAN     = 3'd2,
        CFG_WRAP_LIMIT   = 3'd3,
        CFG_GEAR_RATIO   = 3'd4,
        CFG_CIRCUMF      = 3'd5,
        CFG_CENTER       = 3'd6,
        CFG_ANGLE_SPAN   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [20:0] pos_max;
        logic signed [20:0] pos_min;
        logic        [20:0] pos_span;
        logic        [13:0] wrap_limit;
        logic        [6:0]  gear_ratio;
        logic        [23:0] circumference;
        logic signed [20:0] center;
        logic        [30:0] angle_span;
    } t_cfg;

    localparam logic signed [20:0] RST_POS_MAX    = 21'sd4096;
    localparam logic signed [20:0] RST_POS_MIN    = -21'sd4096;
    localparam logic        [20:0] RST_POS_SPAN   = 21'd8192;
    localparam logic        [13:0] RST_WRAP_LIMIT = 14'd4096;
    localparam logic        [6:0]  RST_GEAR_RATIO = 7'd1;
    localparam logic        [23:0] RST_CIRCUMF    = 24'd0;
    localparam logic signed [20:0] RST_CENTER     = 21'sd0;
    localparam logic        [30:0] RST_ANGLE_SPAN = 31'd411775;

    typedef struct packed {
        logic        [12:0] angle;
        logic signed [20:0] position;
        logic signed [31:0] distance;
        logic signed [31:0] angle_q16;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SUM,
        ST_WRAP_HI,
        ST_WAIT_HI,
        ST_WRAP_LO,
        ST_WAIT_LO,
        ST_STORE,
        ST_DIST_MUL,
        ST_DIST_DIV,
        ST_WAIT_DIST,
        ST_ANG_ADJ,
        ST_ANG_MUL,
        ST_ANG_DIV,
        ST_WAIT_ANG,
        ST_OUT
    } t_state;

    // signed 32-bit saturation of a sign and a quotient magnitude
    function automatic logic [31:0] sat_q(input logic neg, input logic [DIV_DW-1:0] q);
        logic [31:0] r;
        if (!neg) begin
            r = (|q[DIV_DW-1:31]) ? 32'h7FFF_FFFF : q[31:0];
        end else if ((|q[DIV_DW-1:32]) || (q[31] && (|q[30:0]))) begin
            r = 32'h8000_0000;
        end else begin
            r = ~q[31:0] + 32'd1;
        end
        return r;
    endfunction

endpackage

// ===== design/mfo_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfo_div
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module mfo_div
    import mfo_pkg::*;
#(
    parameter int DV = 23
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_DW-1:0] i_dividend,
    input  logic [DV-1:0]     i_divisor,
    input  logic [DIV_CW-1:0] i_count,
    output logic              o_done,
    output logic [DIV_DW-1:0] o_quotient,
    output logic [DV-1:0]     o_remainder
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DV-1:0]     r_rem;
    logic [DIV_DW-1:0] r_quo;
    logic [DV-1:0]     r_dvs;

    logic [DV:0]   shifted;
    logic [DV+1:0] trial;
    logic          take;

    assign shifted = {r_rem, r_quo[DIV_DW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dvs};
    assign take    = ~trial[DV+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend is left-aligned, so after count steps the quotient sits in the low bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? trial[DV-1:0] : shifted[DV-1:0];
            r_quo <= {r_quo[DIV_DW-2:0], take};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== design/mfo_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfo_cfg
// Configuration register file, written by index, no read-back.
// ----------------------------------------------------------------------------
module mfo_cfg
    import mfo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_ADDR_W-1:0] i_addr,
    input  logic [CFG_DATA_W-1:0] i_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_max       <= RST_POS_MAX;
            r_cfg.pos_min       <= RST_POS_MIN;
            r_cfg.pos_span      <= RST_POS_SPAN;
            r_cfg.wrap_limit    <= RST_WRAP_LIMIT;
            r_cfg.gear_ratio    <= RST_GEAR_RATIO;
            r_cfg.circumference <= RST_CIRCUMF;
            r_cfg.center        <= RST_CENTER;
            r_cfg.angle_span    <= RST_ANGLE_SPAN;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_addr))
                CFG_POS_MAX:    r_cfg.pos_max       <= i_wdata[20:0];
                CFG_POS_MIN:    r_cfg.pos_min       <= i_wdata[20:0];
                CFG_POS_SPAN:   r_cfg.pos_span      <= i_wdata[20:0];
                CFG_WRAP_LIMIT: r_cfg.wrap_limit    <= i_wdata[13:0];
                CFG_GEAR_RATIO: r_cfg.gear_ratio    <= i_wdata[6:0];
                CFG_CIRCUMF:    r_cfg.circumference <= i_wdata[23:0];
                CFG_CENTER:     r_cfg.center        <= i_wdata[20:0];
                CFG_ANGLE_SPAN: r_cfg.angle_span    <= i_wdata[30:0];
                default:        r_cfg.angle_span    <= r_cfg.angle_span;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/mfo_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfo_core
// Sequencer and datapath: position tracking, wrap, distance and angle, all
// divisions on one shared bit-serial divider and products on one multiplier.
// ----------------------------------------------------------------------------
module mfo_core
    import mfo_pkg::*;
#(
    parameter int RAW_TICKS_PER_TURN = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_start,
    input  logic [12:0] i_angle,
    output logic        o_ready,
    output logic        o_done,
    input  logic        i_out_ready,
    output t_res        o_res
);

    localparam int GT_W   = $clog2(RAW_TICKS_PER_TURN * 127 + 1);
    localparam int DIV_DV = (GT_W > 21) ? GT_W : 21;

    t_state r_state;
    t_state n_state;

    // tracker state
    logic               r_seeded;
    logic [12:0]        r_prev;
    logic signed [20:0] r_acc;

    // per-item working registers
    logic [12:0]          r_angle;
    logic signed [P_W-1:0] r_delta;
    logic signed [P_W-1:0] r_p;
    logic signed [P_W-1:0] r_rel;
    logic                  r_neg;
    logic [MUL_W-1:0]      r_prod;
    logic [31:0]           r_dist;
    logic [31:0]           r_ang;

    // widened configuration
    logic signed [P_W-1:0] pmax_x, pmin_x, span_x, limit_x, center_x, raw_x;
    logic signed [P_W-1:0] acc_x, angle_x, prev_x, rem_x;
    logic                  span_nz;
    logic [DIV_DV-1:0]     turn_ticks;
    logic [DIV_DV-1:0]     span_dv;

    assign pmax_x   = {{(P_W-21){i_cfg.pos_max[20]}}, i_cfg.pos_max};
    assign pmin_x   = {{(P_W-21){i_cfg.pos_min[20]}}, i_cfg.pos_min};
    assign center_x = {{(P_W-21){i_cfg.center[20]}}, i_cfg.center};
    assign span_x   = {{(P_W-21){1'b0}}, i_cfg.pos_span};
    assign limit_x  = {{(P_W-14){1'b0}}, i_cfg.wrap_limit};
    assign raw_x    = P_W'(RAW_TICKS_PER_TURN);
    assign acc_x    = {{(P_W-21){r_acc[20]}}, r_acc};
    assign angle_x  = {{(P_W-13){1'b0}}, r_angle};
    assign prev_x   = {{(P_W-13){1'b0}}, r_prev};
    assign span_nz  = |i_cfg.pos_span;
    assign span_dv  = DIV_DV'(i_cfg.pos_span);
    assign turn_ticks = DIV_DV'(RAW_TICKS_PER_TURN)
                      * {{(DIV_DV-7){1'b0}}, i_cfg.gear_ratio};

    // shared divider
    logic              div_start;
    logic [DIV_DW-1:0] div_dividend;
    logic [DIV_DV-1:0] div_divisor;
    logic [DIV_CW-1:0] div_count;
    logic              div_done;
    logic [DIV_DW-1:0] div_quo;
    logic [DIV_DV-1:0] div_rem;

    mfo_div #(
        .DV (DIV_DV)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .i_count     (div_count),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign rem_x = {{(P_W-DIV_DV){1'b0}}, div_rem};

    // combinational datapath
    logic signed [P_W-1:0] delta_raw, delta_w;
    logic signed [P_W-1:0] seed_a, seed_b;
    logic signed [P_W-1:0] d_hi, d_lo;
    logic signed [P_W-1:0] rel_adj;
    logic signed [P_W-1:0] rel_neg;
    logic [20:0]           acc_mag;
    logic [MUL_AW-1:0]     mul_a;
    logic [MUL_BW-1:0]     mul_b;
    logic [MUL_W-1:0]      mul_p;

    // the one multiplier, shared by distance and angle
    assign mul_p = {{(MUL_W-MUL_AW){1'b0}}, mul_a} * {{(MUL_W-MUL_BW){1'b0}}, mul_b};

    always_comb begin
        delta_raw = angle_x - prev_x;
        if (delta_raw > limit_x) begin
            delta_w = delta_raw - raw_x;
        end else if (delta_raw < -limit_x) begin
            delta_w = delta_raw + raw_x;
        end else begin
            delta_w = delta_raw;
        end

        // seed frame: at most one span each way
        seed_a = (span_nz && (angle_x > pmax_x)) ? (angle_x - span_x) : angle_x;
        seed_b = (span_nz && (seed_a < pmin_x)) ? (seed_a + span_x) : seed_a;

        // remainder operands for the ceil-multiple wrap
        d_hi = r_p - pmax_x - P_W'(1);
        d_lo = pmin_x - r_p - P_W'(1);

        if (r_rel > pmax_x) begin
            rel_adj = r_rel - span_x;
        end else if (r_rel < pmin_x) begin
            rel_adj = r_rel + span_x;
        end else begin
            rel_adj = r_rel;
        end

        rel_neg = -r_rel;
        acc_mag = r_acc[20] ? (~r_acc + 21'd1) : r_acc;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_start) n_state = ST_DELTA;
            ST_DELTA:     n_state = ST_SUM;
            ST_SUM:       n_state = (r_seeded && span_nz) ? ST_WRAP_HI : ST_STORE;
            ST_WRAP_HI:   n_state = (r_p > pmax_x) ? ST_WAIT_HI : ST_WRAP_LO;
            ST_WAIT_HI:   if (div_done) n_state = ST_WRAP_LO;
            ST_WRAP_LO:   n_state = (r_p < pmin_x) ? ST_WAIT_LO : ST_STORE;
            ST_WAIT_LO:   if (div_done) n_state = ST_STORE;
            ST_STORE:     n_state = ST_DIST_MUL;
            ST_DIST_MUL:  n_state = ST_DIST_DIV;
            ST_DIST_DIV:  n_state = (|i_cfg.gear_ratio) ? ST_WAIT_DIST : ST_ANG_ADJ;
            ST_WAIT_DIST: if (div_done) n_state = ST_ANG_ADJ;
            ST_ANG_ADJ:   n_state = span_nz ? ST_ANG_MUL : ST_OUT;
            ST_ANG_MUL:   n_state = ST_ANG_DIV;
            ST_ANG_DIV:   n_state = ST_WAIT_ANG;
            ST_WAIT_ANG:  if (div_done) n_state = ST_OUT;
            ST_OUT:       if (i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // state outputs: divider launch, multiplier operands and handshake flags
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = span_dv;
        div_count    = DIV_CW'(WRAP_BITS);
        mul_a        = {{(MUL_AW-21){1'b0}}, acc_mag};
        mul_b        = {{(MUL_BW-24){1'b0}}, i_cfg.circumference};
        o_ready      = 1'b0;
        o_done       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_WRAP_HI: begin
                div_start    = r_p > pmax_x;
                div_dividend = {d_hi[WRAP_BITS-1:0], {(DIV_DW-WRAP_BITS){1'b0}}};
            end
            ST_WRAP_LO: begin
                div_start    = r_p < pmin_x;
                div_dividend = {d_lo[WRAP_BITS-1:0], {(DIV_DW-WRAP_BITS){1'b0}}};
            end
            ST_DIST_DIV: begin
                div_start    = |i_cfg.gear_ratio;
                div_dividend = {r_prod[DIST_BITS-1:0], {(DIV_DW-DIST_BITS){1'b0}}};
                div_divisor  = turn_ticks;
                div_count    = DIV_CW'(DIST_BITS);
            end
            ST_ANG_MUL: begin
                mul_a = r_rel[P_W-1] ? rel_neg[MUL_AW-1:0] : r_rel[MUL_AW-1:0];
                mul_b = i_cfg.angle_span;
            end
            ST_ANG_DIV: begin
                div_start    = 1'b1;
                div_dividend = r_prod[ANG_BITS-1:0];
                div_count    = DIV_CW'(ANG_BITS);
            end
            ST_OUT: begin
                o_done = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seeded <= 1'b0;
            r_prev   <= '0;
            r_acc    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_STORE) begin
                r_seeded <= 1'b1;
                r_prev   <= r_angle;
                r_acc    <= r_p[20:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_start) r_angle <= i_angle;
            end
            ST_DELTA: begin
                r_delta <= delta_w;
            end
            ST_SUM: begin
                r_p <= r_seeded ? (acc_x + r_delta) : seed_b;
            end
            ST_WAIT_HI: begin
                if (div_done) r_p <= pmax_x - span_x + P_W'(1) + rem_x;
            end
            ST_WAIT_LO: begin
                if (div_done) r_p <= pmin_x + span_x - P_W'(1) - rem_x;
            end
            ST_DIST_MUL: begin
                r_prod <= mul_p;
                r_rel  <= acc_x - center_x;
                r_neg  <= r_acc[20];
                r_dist <= '0;
            end
            ST_WAIT_DIST: begin
                if (div_done) r_dist <= sat_q(r_neg, div_quo);
            end
            ST_ANG_ADJ: begin
                r_rel <= rel_adj;
                r_neg <= rel_adj[P_W-1];
                r_ang <= '0;
            end
            ST_ANG_MUL: begin
                r_prod <= mul_p;
            end
            ST_WAIT_ANG: begin
                if (div_done) r_ang <= sat_q(r_neg, div_quo);
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    assign o_res.angle     = r_angle;
    assign o_res.position  = r_acc;
    assign o_res.distance  = r_dist;
    assign o_res.angle_q16 = r_ang;

endmodule

// ===== design/motor_feedback_odometry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_odometry_top
// Multi-turn encoder position tracker for one motor feedback stream.
// ----------------------------------------------------------------------------
// Input stream: one feedback frame per word (angle, speed, torque,
// temperature). Output stream: one result word per frame, carrying the
// pass-through fields, the wrapped geared position, the travel distance and
// the recentred angle in Q16.16 radians. Configuration registers are written
// through the index/data port; the user must write them only while no frame
// is in flight, as the block itself does not enforce this. One frame at a
// time: the next frame is accepted once the result is in the output register.
// The shared one-bit-per-cycle divider runs 44 steps for distance, 53 for
// angle, and 23 for each wrap that is needed.
// Reset clears the tracker, so the first frame after reset seeds the position
// from its raw angle; registers return to their default values.
// A finished result sits in the output register until taken; the next frame
// is accepted meanwhile, and the sequencer holds its own result if the output
// register is still occupied.
// ----------------------------------------------------------------------------
module motor_feedback_odometry_top
    import mfo_pkg::*;
#(
    parameter int RAW_TICKS_PER_TURN = 8192
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // raw_angle[12:0], raw_speed[28:13], raw_torque[44:29], raw_temperature[52:45]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // angle_out[12:0], speed_out[28:13], torque_out[44:29], temperature_out[52:45],
    // geared_position[73:53], travel_distance[105:74], centered_angle_q16[137:106]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg cfg;
    t_res res;

    logic in_accept;
    logic core_ready;
    logic core_done;
    logic out_free;
    logic out_load;

    logic [15:0]            r_speed;
    logic [15:0]            r_torque;
    logic [7:0]             r_temp;
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    mfo_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    mfo_core #(
        .RAW_TICKS_PER_TURN (RAW_TICKS_PER_TURN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_start     (in_accept),
        .i_angle     (s_axis_tdata[12:0]),
        .o_ready     (core_ready),
        .o_done      (core_done),
        .i_out_ready (out_free),
        .o_res       (res)
    );

    assign s_axis_tready = core_ready;
    assign in_accept     = s_axis_tvalid & core_ready;
    assign out_free      = ~r_m_valid | m_axis_tready;
    assign out_load      = core_done & out_free;

    // pass-through fields of the frame in flight
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_speed  <= s_axis_tdata[28:13];
            r_torque <= s_axis_tdata[44:29];
            r_temp   <= s_axis_tdata[52:45];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {6'b0, res.angle_q16, res.distance, res.position,
                         r_temp, r_torque, r_speed, res.angle};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
